@@ hdl/trgvt_pkg.sv @@
// shared types, codes and helpers of the token ring gvt estimator
package trgvt_pkg;

    // time width of every timestamp and gvt field
    localparam int TIME_BITS = 32;
    // largest ring the node will address
    localparam int MAX_NODES = 256;
    localparam int NODE_BITS = 8;
    localparam int RING_BITS = 9;
    localparam int COUNT_BITS = 16;
    localparam int PERIOD_BITS = 16;
    localparam int ROUND_BITS = 8;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_INDEX_BITS = 2;

    typedef logic [TIME_BITS-1:0] gvt_time_t;

    // input item kinds
    typedef enum logic [2:0] {
        MODE_TICK   = 3'd0,
        MODE_SEND   = 3'd1,
        MODE_RECV   = 3'd2,
        MODE_START  = 3'd3,
        MODE_TOKEN  = 3'd4,
        MODE_UPDATE = 3'd5
    } mode_t;

    // result kinds
    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_COLOR_TAG = 3'd1,
        ACT_TOKEN     = 3'd2,
        ACT_BROADCAST = 3'd3,
        ACT_GVT_SET   = 3'd4
    } action_t;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_NODE_ID    = 2'd0,
        CFG_NODE_COUNT = 2'd1,
        CFG_GVT_PERIOD = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [NODE_BITS-1:0]   node_id;
        logic [RING_BITS-1:0]   node_count;
        logic [PERIOD_BITS-1:0] gvt_period;
    } cfg_t;

    typedef struct packed {
        logic                         node_color;
        logic signed [COUNT_BITS-1:0] white_count;
        gvt_time_t                    red_min_stamp;
        logic [ROUND_BITS-1:0]        token_round;
        logic                         token_pending;
        logic [PERIOD_BITS-1:0]       period_count;
        gvt_time_t                    current_gvt;
    } node_state_t;

    typedef struct packed {
        mode_t                        mode;
        gvt_time_t                    event_time;
        logic                         event_color;
        gvt_time_t                    local_time;
        gvt_time_t                    token_clock;
        gvt_time_t                    token_min_stamp;
        logic signed [COUNT_BITS-1:0] token_count;
        gvt_time_t                    new_gvt;
    } item_t;

    typedef struct packed {
        action_t                      action;
        logic                         period_elapsed;
        logic                         tag_color;
        logic [NODE_BITS-1:0]         token_dest;
        gvt_time_t                    out_clock;
        gvt_time_t                    out_min_stamp;
        logic signed [COUNT_BITS-1:0] out_count;
        gvt_time_t                    gvt_value;
        logic                         fossil_collect;
    } result_t;

    // clamp a one-bit-grown count back into the signed count range
    function automatic logic signed [COUNT_BITS-1:0] sat_count(
        input logic signed [COUNT_BITS:0] v
    );
        logic signed [COUNT_BITS-1:0] r;
        if (v[COUNT_BITS] != v[COUNT_BITS-1])
        begin
            r = v[COUNT_BITS] ? {1'b1, {(COUNT_BITS-1){1'b0}}}
                              : {1'b0, {(COUNT_BITS-1){1'b1}}};
        end
        else
        begin
            r = v[COUNT_BITS-1:0];
        end
        return r;
    endfunction

    function automatic gvt_time_t tmin(input gvt_time_t a, input gvt_time_t b);
        return (a < b) ? a : b;
    endfunction

endpackage

@@ hdl/trgvt_core.sv @@
// next node state and result for one item, all combinational
module trgvt_core (
    input  trgvt_pkg::cfg_t        cfg,
    input  trgvt_pkg::node_state_t state,
    input  trgvt_pkg::item_t       item,
    output trgvt_pkg::node_state_t state_next,
    output trgvt_pkg::result_t     result
);

    localparam trgvt_pkg::gvt_time_t TIME_INF = '1;

    logic [trgvt_pkg::RING_BITS-1:0]         ring_size;
    logic [trgvt_pkg::RING_BITS-1:0]         next_node;
    logic [trgvt_pkg::NODE_BITS-1:0]         dest;
    logic [trgvt_pkg::ROUND_BITS-1:0]        round_inc;
    logic signed [trgvt_pkg::COUNT_BITS:0]   token_sum;
    logic signed [trgvt_pkg::COUNT_BITS:0]   count_up;
    logic signed [trgvt_pkg::COUNT_BITS:0]   count_down;
    logic [trgvt_pkg::PERIOD_BITS-1:0]       period_inc;
    trgvt_pkg::gvt_time_t                    red_eff;
    trgvt_pkg::gvt_time_t                    token_gvt;

    // ring size clamp and next hop
    assign ring_size = (cfg.node_count > trgvt_pkg::RING_BITS'(trgvt_pkg::MAX_NODES))
                     ? trgvt_pkg::RING_BITS'(trgvt_pkg::MAX_NODES) : cfg.node_count;
    assign next_node = {1'b0, cfg.node_id} + trgvt_pkg::RING_BITS'(1);
    assign dest      = (next_node >= ring_size) ? '0
                                                : next_node[trgvt_pkg::NODE_BITS-1:0];
    assign round_inc = (&state.token_round) ? state.token_round
                                            : state.token_round + 1'b1;

    // counts grown by one bit so overflow shows before saturation
    assign token_sum  = {state.white_count[trgvt_pkg::COUNT_BITS-1], state.white_count}
                      + {item.token_count[trgvt_pkg::COUNT_BITS-1], item.token_count};
    assign count_up   = {state.white_count[trgvt_pkg::COUNT_BITS-1], state.white_count}
                      + (trgvt_pkg::COUNT_BITS+1)'(1);
    assign count_down = {state.white_count[trgvt_pkg::COUNT_BITS-1], state.white_count}
                      - (trgvt_pkg::COUNT_BITS+1)'(1);
    assign period_inc = state.period_count + 1'b1;
    assign token_gvt  = trgvt_pkg::tmin(item.token_clock, item.token_min_stamp);

    // a non-initiator turns red on its first token
    assign red_eff = (cfg.node_id != '0 && !state.node_color) ? TIME_INF
                                                              : state.red_min_stamp;

    // per-mode update
    always_comb
    begin
        state_next = state;
        result     = '0;
        result.action = trgvt_pkg::ACT_NONE;
        case (item.mode)
            trgvt_pkg::MODE_TICK:
            begin
                if (!state.token_pending)
                begin
                    if (period_inc == cfg.gvt_period)
                    begin
                        state_next.period_count = '0;
                        result.period_elapsed   = 1'b1;
                    end
                    else
                    begin
                        state_next.period_count = period_inc;
                    end
                end
            end
            trgvt_pkg::MODE_SEND:
            begin
                result.action    = trgvt_pkg::ACT_COLOR_TAG;
                result.tag_color = state.node_color;
                if (!state.node_color)
                begin
                    state_next.white_count = trgvt_pkg::sat_count(count_up);
                end
                else
                begin
                    state_next.red_min_stamp =
                        trgvt_pkg::tmin(state.red_min_stamp, item.event_time);
                end
            end
            trgvt_pkg::MODE_RECV:
            begin
                if (!item.event_color)
                begin
                    state_next.white_count = trgvt_pkg::sat_count(count_down);
                end
            end
            trgvt_pkg::MODE_START:
            begin
                if (cfg.node_id == '0)
                begin
                    if (ring_size > trgvt_pkg::RING_BITS'(1))
                    begin
                        if (!state.token_pending)
                        begin
                            result.action          = trgvt_pkg::ACT_TOKEN;
                            result.token_dest      = dest;
                            result.out_clock       = item.local_time;
                            result.out_min_stamp   = TIME_INF;
                            result.out_count       = state.white_count;
                            state_next.token_round   = round_inc;
                            state_next.node_color    = 1'b1;
                            state_next.white_count   = '0;
                            state_next.red_min_stamp = TIME_INF;
                            state_next.token_pending = 1'b1;
                        end
                    end
                    else
                    begin
                        result.action          = trgvt_pkg::ACT_GVT_SET;
                        result.fossil_collect  = item.local_time > state.current_gvt;
                        state_next.current_gvt = item.local_time;
                    end
                end
            end
            trgvt_pkg::MODE_TOKEN:
            begin
                if (cfg.node_id == '0 && state.token_round > trgvt_pkg::ROUND_BITS'(1)
                    && token_sum == '0)
                begin
                    // round closed with nothing in transit
                    result.action = trgvt_pkg::ACT_BROADCAST;
                    if (token_gvt > state.current_gvt)
                    begin
                        state_next.current_gvt = token_gvt;
                        result.fossil_collect  = 1'b1;
                    end
                    state_next.token_round   = '0;
                    state_next.white_count   = '0;
                    state_next.node_color    = 1'b0;
                    state_next.token_pending = 1'b0;
                end
                else
                begin
                    // fold local figures in and pass the token on
                    result.action            = trgvt_pkg::ACT_TOKEN;
                    result.token_dest        = dest;
                    result.out_clock         = trgvt_pkg::tmin(item.token_clock,
                                                               item.local_time);
                    result.out_min_stamp     = trgvt_pkg::tmin(item.token_min_stamp,
                                                               red_eff);
                    result.out_count         = trgvt_pkg::sat_count(token_sum);
                    state_next.red_min_stamp = red_eff;
                    if (cfg.node_id != '0)
                    begin
                        state_next.node_color = 1'b1;
                    end
                    state_next.token_round   = round_inc;
                    state_next.white_count   = '0;
                end
            end
            trgvt_pkg::MODE_UPDATE:
            begin
                result.action = trgvt_pkg::ACT_GVT_SET;
                if (item.new_gvt > state.current_gvt)
                begin
                    state_next.current_gvt = item.new_gvt;
                    result.fossil_collect  = 1'b1;
                end
                state_next.token_round = '0;
                state_next.node_color  = 1'b0;
            end
            default:
            begin
                result.action = trgvt_pkg::ACT_NONE;
            end
        endcase
        result.gvt_value = state_next.current_gvt;
    end

endmodule

@@ hdl/token_ring_gvt_estimator_unit.sv @@
// top level of one token ring gvt estimator node
// One node of a two-color token ring GVT estimator. Each accepted item
// (tick, send, receive, start, token or gvt update) yields exactly one result
// in the output register, loaded at the edge that accepts the item; the node
// takes a new item in every cycle as long as the output register is empty or
// being drained in the same cycle, so the sustained rate is one item per clock.
// The result comes from the single pass of compare and add logic between the
// node state registers and the output register. Configuration writes (node id,
// ring size, period) take effect at the edge where cfg_we is high and should
// only happen while the node is idle.
module token_ring_gvt_estimator_unit (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // configuration write port
    input  logic                                     cfg_we,
    input  logic [trgvt_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [trgvt_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    // input item channel
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [2:0]                               mode,
    input  trgvt_pkg::gvt_time_t                     event_time,
    input  logic                                     event_color,
    input  trgvt_pkg::gvt_time_t                     local_time,
    input  trgvt_pkg::gvt_time_t                     token_clock,
    input  trgvt_pkg::gvt_time_t                     token_min_stamp,
    input  logic signed [trgvt_pkg::COUNT_BITS-1:0]  token_count,
    input  trgvt_pkg::gvt_time_t                     new_gvt,
    // result channel
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [2:0]                               action,
    output logic                                     period_elapsed,
    output logic                                     tag_color,
    output logic [trgvt_pkg::NODE_BITS-1:0]          token_dest,
    output trgvt_pkg::gvt_time_t                     out_clock,
    output trgvt_pkg::gvt_time_t                     out_min_stamp,
    output logic signed [trgvt_pkg::COUNT_BITS-1:0]  out_count,
    output trgvt_pkg::gvt_time_t                     gvt_value,
    output logic                                     fossil_collect
);

    trgvt_pkg::cfg_t        cfg_reg;
    trgvt_pkg::node_state_t state_reg;
    trgvt_pkg::node_state_t state_next;
    trgvt_pkg::item_t       item;
    trgvt_pkg::result_t     result_next;
    trgvt_pkg::result_t     result_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   in_xfer;

    // handshake
    assign in_ready       = !out_valid_reg || out_ready;
    assign in_xfer        = in_valid && in_ready;
    assign out_valid_next = in_xfer || (out_valid_reg && !out_ready);

    // gather the input fields
    always_comb
    begin
        item.mode            = trgvt_pkg::mode_t'(mode);
        item.event_time      = event_time;
        item.event_color     = event_color;
        item.local_time      = local_time;
        item.token_clock     = token_clock;
        item.token_min_stamp = token_min_stamp;
        item.token_count     = token_count;
        item.new_gvt         = new_gvt;
    end

    trgvt_core u_core (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item),
        .state_next (state_next),
        .result     (result_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_id    <= '0;
            cfg_reg.node_count <= trgvt_pkg::RING_BITS'(1);
            cfg_reg.gvt_period <= trgvt_pkg::PERIOD_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (trgvt_pkg::cfg_reg_t'(cfg_index))
                trgvt_pkg::CFG_NODE_ID:
                    cfg_reg.node_id <= cfg_data[trgvt_pkg::NODE_BITS-1:0];
                trgvt_pkg::CFG_NODE_COUNT:
                    cfg_reg.node_count <= cfg_data[trgvt_pkg::RING_BITS-1:0];
                trgvt_pkg::CFG_GVT_PERIOD:
                    cfg_reg.gvt_period <= cfg_data[trgvt_pkg::PERIOD_BITS-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // node state, updated on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.node_color    <= 1'b0;
            state_reg.white_count   <= '0;
            state_reg.red_min_stamp <= '1;
            state_reg.token_round   <= '0;
            state_reg.token_pending <= 1'b0;
            state_reg.period_count  <= '0;
            state_reg.current_gvt   <= '0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign action         = result_reg.action;
    assign period_elapsed = result_reg.period_elapsed;
    assign tag_color      = result_reg.tag_color;
    assign token_dest     = result_reg.token_dest;
    assign out_clock      = result_reg.out_clock;
    assign out_min_stamp  = result_reg.out_min_stamp;
    assign out_count      = result_reg.out_count;
    assign gvt_value      = result_reg.gvt_value;
    assign fossil_collect = result_reg.fossil_collect;

    // a closed round always clears the pending token
    a_broadcast_clears_pending: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_xfer && result_next.action == trgvt_pkg::ACT_BROADCAST)
            |=> !state_reg.token_pending
    ) else $error("token still pending after gvt broadcast");

    // gvt only drops through a start on a single-node ring
    a_gvt_monotonic: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!(in_xfer && item.mode == trgvt_pkg::MODE_START))
            |=> (state_reg.current_gvt >= $past(state_reg.current_gvt))
    ) else $error("gvt decreased");

    // fossil collection comes only with a gvt result
    a_fossil_with_gvt: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.fossil_collect)
            |-> (result_reg.action == trgvt_pkg::ACT_BROADCAST
                 || result_reg.action == trgvt_pkg::ACT_GVT_SET)
    ) else $error("fossil collect without gvt change");

    // a red tag only goes out on a color tag result
    a_tag_only_on_send: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.tag_color)
            |-> (result_reg.action == trgvt_pkg::ACT_COLOR_TAG)
    ) else $error("tag color set outside a color tag result");

    // reported gvt tracks the state after the transfer
    a_gvt_reported: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_xfer |=> (result_reg.gvt_value == state_reg.current_gvt)
    ) else $error("reported gvt differs from node state");

endmodule

@@ tb/sv/token_ring_gvt_estimator_unit_test.sv @@
// self-checking testbench for one token ring gvt estimator node with its own node predictor
module token_ring_gvt_estimator_unit_test;

    // unused mode codes that the node must ignore
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    localparam int RANDOM_PER_PHASE = 170;
    localparam int MAX_SHOWN = 200;

    typedef struct packed {
        logic [2:0]                              mode;
        trgvt_pkg::gvt_time_t                    event_time;
        logic                                    event_color;
        trgvt_pkg::gvt_time_t                    local_time;
        trgvt_pkg::gvt_time_t                    token_clock;
        trgvt_pkg::gvt_time_t                    token_min_stamp;
        logic signed [trgvt_pkg::COUNT_BITS-1:0] token_count;
        trgvt_pkg::gvt_time_t                    new_gvt;
    } node_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [trgvt_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [trgvt_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] mode = '0;
    trgvt_pkg::gvt_time_t event_time = '0;
    logic event_color = 1'b0;
    trgvt_pkg::gvt_time_t local_time = '0;
    trgvt_pkg::gvt_time_t token_clock = '0;
    trgvt_pkg::gvt_time_t token_min_stamp = '0;
    logic signed [trgvt_pkg::COUNT_BITS-1:0] token_count = '0;
    trgvt_pkg::gvt_time_t new_gvt = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] action;
    logic period_elapsed;
    logic tag_color;
    logic [trgvt_pkg::NODE_BITS-1:0] token_dest;
    trgvt_pkg::gvt_time_t out_clock;
    trgvt_pkg::gvt_time_t out_min_stamp;
    logic signed [trgvt_pkg::COUNT_BITS-1:0] out_count;
    trgvt_pkg::gvt_time_t gvt_value;
    logic fossil_collect;

    // items waiting to be offered and node results still owed
    node_item_t pending_items[$];
    trgvt_pkg::result_t owed_results[$];
    node_item_t on_wire;
    trgvt_pkg::result_t want;

    // predictor state on the accept side and on the planning side
    trgvt_pkg::node_state_t model_st;
    trgvt_pkg::node_state_t plan_st;
    trgvt_pkg::cfg_t node_cfg;

    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int unsigned ready_cycle = 0;
    int unsigned hold_left = 0;
    int items_in = 0;
    int results_checked = 0;
    int mismatches = 0;
    int tokens_seen = 0;
    int broadcasts_seen = 0;
    int gvt_sets_seen = 0;
    int periods_seen = 0;
    int fossils_seen = 0;

    token_ring_gvt_estimator_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .event_time     (event_time),
        .event_color    (event_color),
        .local_time     (local_time),
        .token_clock    (token_clock),
        .token_min_stamp(token_min_stamp),
        .token_count    (token_count),
        .new_gvt        (new_gvt),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .action         (action),
        .period_elapsed (period_elapsed),
        .tag_color      (tag_color),
        .token_dest     (token_dest),
        .out_clock      (out_clock),
        .out_min_stamp  (out_min_stamp),
        .out_count      (out_count),
        .gvt_value      (gvt_value),
        .fossil_collect (fossil_collect)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic trgvt_pkg::node_state_t fresh_state();
        trgvt_pkg::node_state_t st;
        st = '0;
        st.red_min_stamp = '1;
        return st;
    endfunction

    function automatic trgvt_pkg::gvt_time_t earlier_of(input trgvt_pkg::gvt_time_t a,
                                                        input trgvt_pkg::gvt_time_t b);
        trgvt_pkg::gvt_time_t v;
        v = (a < b) ? a : b;
        return v;
    endfunction

    // white counts clamp to the signed 16-bit range
    function automatic logic signed [trgvt_pkg::COUNT_BITS-1:0] clamp_count(input int v);
        logic signed [trgvt_pkg::COUNT_BITS-1:0] c;
        if (v > 32767)
            c = 16'sh7FFF;
        else if (v < -32768)
            c = 16'sh8000;
        else
            c = v[trgvt_pkg::COUNT_BITS-1:0];
        return c;
    endfunction

    function automatic logic [trgvt_pkg::RING_BITS-1:0] ring_of(input trgvt_pkg::cfg_t cf);
        logic [trgvt_pkg::RING_BITS-1:0] n;
        n = (cf.node_count > trgvt_pkg::MAX_NODES)
          ? trgvt_pkg::RING_BITS'(trgvt_pkg::MAX_NODES) : cf.node_count;
        return n;
    endfunction

    // forward the token to the next ring node carrying the current white count
    task automatic pass_token(inout trgvt_pkg::node_state_t st, input trgvt_pkg::cfg_t cf,
                              input trgvt_pkg::gvt_time_t clock_min,
                              input trgvt_pkg::gvt_time_t stamp_min,
                              inout trgvt_pkg::result_t r);
        logic [trgvt_pkg::RING_BITS:0] next_node;
        next_node = {2'b00, cf.node_id} + 10'd1;
        if (next_node >= ring_of(cf))
            next_node = '0;
        if (st.token_round != '1)
            st.token_round = st.token_round + 1'b1;
        r.action = trgvt_pkg::ACT_TOKEN;
        r.token_dest = next_node[trgvt_pkg::NODE_BITS-1:0];
        r.out_clock = clock_min;
        r.out_min_stamp = stamp_min;
        r.out_count = st.white_count;
    endtask

    // gvt only moves forward here
    task automatic lift_gvt(inout trgvt_pkg::node_state_t st, input trgvt_pkg::gvt_time_t v,
                            inout trgvt_pkg::result_t r);
        if (v > st.current_gvt)
        begin
            st.current_gvt = v;
            r.fossil_collect = 1'b1;
        end
    endtask

    // next node state and the result of one item
    task automatic advance_node(inout trgvt_pkg::node_state_t st, input trgvt_pkg::cfg_t cf,
                                input node_item_t it, output trgvt_pkg::result_t r);
        int total;
        r = '0;
        case (it.mode)
            trgvt_pkg::MODE_TICK:
            begin
                if (!st.token_pending)
                begin
                    st.period_count = st.period_count + 1'b1;
                    if (st.period_count == cf.gvt_period)
                    begin
                        st.period_count = '0;
                        r.period_elapsed = 1'b1;
                    end
                end
            end
            trgvt_pkg::MODE_SEND:
            begin
                r.action = trgvt_pkg::ACT_COLOR_TAG;
                r.tag_color = st.node_color;
                if (!st.node_color)
                    st.white_count = clamp_count(int'($signed(st.white_count)) + 1);
                else
                    st.red_min_stamp = earlier_of(st.red_min_stamp, it.event_time);
            end
            trgvt_pkg::MODE_RECV:
            begin
                if (!it.event_color)
                    st.white_count = clamp_count(int'($signed(st.white_count)) - 1);
            end
            trgvt_pkg::MODE_START:
            begin
                if (cf.node_id == '0)
                begin
                    if (ring_of(cf) > 1)
                    begin
                        if (!st.token_pending)
                        begin
                            pass_token(st, cf, it.local_time, '1, r);
                            st.node_color = 1'b1;
                            st.white_count = '0;
                            st.red_min_stamp = '1;
                            st.token_pending = 1'b1;
                        end
                    end
                    else
                    begin
                        // single node: gvt follows local time, even downward
                        r.action = trgvt_pkg::ACT_GVT_SET;
                        r.fossil_collect = it.local_time > st.current_gvt;
                        st.current_gvt = it.local_time;
                    end
                end
            end
            trgvt_pkg::MODE_TOKEN:
            begin
                total = int'($signed(st.white_count)) + int'($signed(it.token_count));
                if (cf.node_id == '0 && st.token_round > 1 && total == 0)
                begin
                    lift_gvt(st, earlier_of(it.token_clock, it.token_min_stamp), r);
                    st.token_round = '0;
                    st.white_count = '0;
                    st.node_color = 1'b0;
                    st.token_pending = 1'b0;
                    r.action = trgvt_pkg::ACT_BROADCAST;
                end
                else
                begin
                    if (cf.node_id != '0 && !st.node_color)
                    begin
                        st.red_min_stamp = '1;
                        st.node_color = 1'b1;
                    end
                    st.white_count = clamp_count(total);
                    pass_token(st, cf, earlier_of(it.token_clock, it.local_time),
                               earlier_of(it.token_min_stamp, st.red_min_stamp), r);
                    st.white_count = '0;
                end
            end
            trgvt_pkg::MODE_UPDATE:
            begin
                lift_gvt(st, it.new_gvt, r);
                st.token_round = '0;
                st.node_color = 1'b0;
                r.action = trgvt_pkg::ACT_GVT_SET;
            end
            default:
            begin
            end
        endcase
        r.gvt_value = st.current_gvt;
    endtask

    // timestamps lean toward small values so minimums and gvt steps interact
    function automatic trgvt_pkg::gvt_time_t rand_stamp();
        trgvt_pkg::gvt_time_t v;
        case ($urandom_range(9))
            0: v = '0;
            1: v = '1;
            2, 3, 4, 5: v = $urandom_range(2000);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic node_item_t rand_item(input logic [2:0] m);
        node_item_t it;
        it.mode = m;
        it.event_time = rand_stamp();
        it.event_color = 1'($urandom_range(1));
        it.local_time = rand_stamp();
        it.token_clock = rand_stamp();
        it.token_min_stamp = rand_stamp();
        it.token_count = trgvt_pkg::COUNT_BITS'($urandom);
        it.new_gvt = rand_stamp();
        return it;
    endfunction

    // queue one item and advance the planning copy of the node
    task automatic plan(input node_item_t it);
        trgvt_pkg::result_t scratch;
        pending_items.push_back(it);
        advance_node(plan_st, node_cfg, it, scratch);
    endtask

    // random traffic, tokens mostly closing the white count exactly
    task automatic plan_random(input int n);
        node_item_t it;
        int roll;
        int counted;
        counted = 0;
        while (counted < n)
        begin
            roll = $urandom_range(99);
            if (roll < 15)
                it = rand_item(trgvt_pkg::MODE_TICK);
            else if (roll < 35)
                it = rand_item(trgvt_pkg::MODE_SEND);
            else if (roll < 50)
                it = rand_item(trgvt_pkg::MODE_RECV);
            else if (roll < 60)
                it = rand_item(trgvt_pkg::MODE_START);
            else if (roll < 85)
            begin
                it = rand_item(trgvt_pkg::MODE_TOKEN);
                roll = $urandom_range(9);
                if (roll < 6)
                    it.token_count = -plan_st.white_count;
                else if (roll < 8)
                    it.token_count = trgvt_pkg::COUNT_BITS'($urandom_range(6) - 3);
            end
            else if (roll < 94)
            begin
                it = rand_item(trgvt_pkg::MODE_UPDATE);
                if ($urandom_range(1))
                    it.new_gvt = plan_st.current_gvt + $urandom_range(500);
            end
            else
                it = rand_item(roll[0] ? MODE_SPARE_A : MODE_SPARE_B);
            plan(it);
            if (it.mode <= trgvt_pkg::MODE_UPDATE)
                counted++;
        end
    endtask

    // wait until the node has returned every owed result
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || owed_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input trgvt_pkg::cfg_reg_t idx,
                             input logic [trgvt_pkg::CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            trgvt_pkg::CFG_NODE_ID:
                node_cfg.node_id = data[trgvt_pkg::NODE_BITS-1:0];
            trgvt_pkg::CFG_NODE_COUNT:
                node_cfg.node_count = data[trgvt_pkg::RING_BITS-1:0];
            trgvt_pkg::CFG_GVT_PERIOD:
                node_cfg.gvt_period = data[trgvt_pkg::PERIOD_BITS-1:0];
            default:
            begin
            end
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_phase(input logic [trgvt_pkg::CFG_DATA_BITS-1:0] id_w,
                             input logic [trgvt_pkg::CFG_DATA_BITS-1:0] count_w,
                             input logic [trgvt_pkg::CFG_DATA_BITS-1:0] period_w,
                             input int send_pct, input int recv_pct);
        wait_drained();
        write_reg(trgvt_pkg::CFG_NODE_ID, id_w);
        write_reg(trgvt_pkg::CFG_NODE_COUNT, count_w);
        write_reg(trgvt_pkg::CFG_GVT_PERIOD, period_w);
        sender_idle_pct = send_pct;
        receiver_idle_pct = recv_pct;
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (got_v !== exp_v)
        begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("%0t mismatch on %s: expected %h actual %h",
                         $time, name, exp_v, got_v);
        end
    endtask

    // driver: predicts each accepted transfer and offers the next item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                advance_node(model_st, node_cfg, on_wire, want);
                owed_results.push_back(want);
                items_in++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    on_wire = pending_items.pop_front();
                    in_valid <= 1'b1;
                    mode <= on_wire.mode;
                    event_time <= on_wire.event_time;
                    event_color <= on_wire.event_color;
                    local_time <= on_wire.local_time;
                    token_clock <= on_wire.token_clock;
                    token_min_stamp <= on_wire.token_min_stamp;
                    token_count <= on_wire.token_count;
                    new_gvt <= on_wire.new_gvt;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result ready: random stalls plus a long hold-off now and then
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            ready_cycle <= ready_cycle + 1;
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (ready_cycle % 3000 == 1500)
            begin
                out_ready <= 1'b0;
                hold_left <= 120;
            end
            else
                out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // monitor: each result transfer against the oldest owed result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_results.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected result: expected none actual action %0d", $time, action);
            end
            else
            begin
                trgvt_pkg::result_t exp_r;
                exp_r = owed_results.pop_front();
                results_checked++;
                check_field("action", 64'(exp_r.action), 64'(action));
                check_field("period_elapsed", 64'(exp_r.period_elapsed), 64'(period_elapsed));
                check_field("tag_color", 64'(exp_r.tag_color), 64'(tag_color));
                check_field("token_dest", 64'(exp_r.token_dest), 64'(token_dest));
                check_field("out_clock", 64'(exp_r.out_clock), 64'(out_clock));
                check_field("out_min_stamp", 64'(exp_r.out_min_stamp), 64'(out_min_stamp));
                check_field("out_count", 64'(exp_r.out_count), 64'(out_count));
                check_field("gvt_value", 64'(exp_r.gvt_value), 64'(gvt_value));
                check_field("fossil_collect", 64'(exp_r.fossil_collect), 64'(fossil_collect));
                if (exp_r.action == trgvt_pkg::ACT_TOKEN)
                    tokens_seen++;
                if (exp_r.action == trgvt_pkg::ACT_BROADCAST)
                    broadcasts_seen++;
                if (exp_r.action == trgvt_pkg::ACT_GVT_SET)
                    gvt_sets_seen++;
                if (exp_r.period_elapsed)
                    periods_seen++;
                if (exp_r.fossil_collect)
                    fossils_seen++;
            end
        end
    end

    // stimulus
    initial
    begin
        node_item_t it;
        model_st = fresh_state();
        plan_st = fresh_state();
        node_cfg.node_id = '0;
        node_cfg.node_count = 9'd1;
        node_cfg.gvt_period = 16'd1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // initiator on a ring of four, directed walk through one full round
        set_phase(16'd0, 16'd4, 16'd3, 12, 81);
        repeat (3) plan(rand_item(trgvt_pkg::MODE_TICK));
        plan(rand_item(trgvt_pkg::MODE_SEND));
        it = rand_item(trgvt_pkg::MODE_RECV);
        it.event_color = 1'b0;
        plan(it);
        it = rand_item(trgvt_pkg::MODE_RECV);
        it.event_color = 1'b1;
        plan(it);
        plan(rand_item(trgvt_pkg::MODE_SEND));
        it = rand_item(trgvt_pkg::MODE_START);
        it.local_time = 32'd100;
        plan(it);
        // tick is held while the token is out
        plan(rand_item(trgvt_pkg::MODE_TICK));
        it = rand_item(trgvt_pkg::MODE_SEND);
        it.event_time = '0;
        plan(it);
        it = rand_item(trgvt_pkg::MODE_SEND);
        it.event_time = '1;
        plan(it);
        // second start while a token is pending
        plan(rand_item(trgvt_pkg::MODE_START));
        it = rand_item(trgvt_pkg::MODE_TOKEN);
        it.token_count = 16'sd5;
        plan(it);
        // token comes back clean after the first round: broadcast
        it = rand_item(trgvt_pkg::MODE_TOKEN);
        it.token_count = '0;
        it.token_clock = 32'd200;
        it.token_min_stamp = 32'd150;
        plan(it);
        // update below the gvt, then above it
        it = rand_item(trgvt_pkg::MODE_UPDATE);
        it.new_gvt = 32'd100;
        plan(it);
        it = rand_item(trgvt_pkg::MODE_UPDATE);
        it.new_gvt = 32'd1000;
        plan(it);
        it = '1;
        it.mode = MODE_SPARE_A;
        plan(it);
        it.mode = MODE_SPARE_B;
        plan(it);
        // token count saturates high and low
        plan(rand_item(trgvt_pkg::MODE_SEND));
        it = rand_item(trgvt_pkg::MODE_TOKEN);
        it.token_count = 16'sh7FFF;
        plan(it);
        repeat (2)
        begin
            it = rand_item(trgvt_pkg::MODE_RECV);
            it.event_color = 1'b0;
            plan(it);
        end
        it = rand_item(trgvt_pkg::MODE_TOKEN);
        it.token_count = 16'sh8000;
        plan(it);
        plan_random(RANDOM_PER_PHASE);

        // sender mostly busy, receiver mostly stalled
        set_phase(16'd2, 16'd3, 16'd1, 12, 81);
        plan_random(RANDOM_PER_PHASE);
        set_phase(16'd0, 16'd1, 16'd5, 12, 81);
        plan_random(RANDOM_PER_PHASE);

        // sender mostly idle, receiver mostly ready; upper data bits are dropped
        set_phase(16'hC3FF, 16'd256, 16'hFFFF, 81, 12);
        plan_random(RANDOM_PER_PHASE);
        set_phase(16'd0, 16'd0, 16'd2, 81, 12);
        plan_random(RANDOM_PER_PHASE);
        set_phase(16'd5, 16'd300, 16'd7, 81, 12);
        plan_random(RANDOM_PER_PHASE);

        // no idling on either side
        set_phase(16'd0, 16'hFFFF, 16'd1, 0, 0);
        plan_random(RANDOM_PER_PHASE);
        set_phase(16'd7, 16'd3, 16'd4, 0, 0);
        plan_random(RANDOM_PER_PHASE);
        set_phase(16'd1, 16'd2, 16'd10, 0, 0);
        plan_random(RANDOM_PER_PHASE);

        // period zero does not fire within a short run of ticks
        set_phase(16'd9, 16'd20, 16'd0, 0, 0);
        repeat (40) plan(rand_item(trgvt_pkg::MODE_TICK));

        // round counter sticks at its top on the initiator
        set_phase(16'd0, 16'd2, 16'd3, 0, 0);
        while (plan_st.token_pending)
        begin
            it = rand_item(trgvt_pkg::MODE_TOKEN);
            it.token_count = -plan_st.white_count;
            plan(it);
        end
        plan(rand_item(trgvt_pkg::MODE_UPDATE));
        plan(rand_item(trgvt_pkg::MODE_START));
        repeat (255)
        begin
            it = rand_item(trgvt_pkg::MODE_TOKEN);
            it.token_count = 16'sd1;
            plan(it);
        end
        it = rand_item(trgvt_pkg::MODE_TOKEN);
        it.token_count = '0;
        plan(it);

        wait_drained();
        if (owed_results.size() != 0)
            mismatches++;
        $display("run covered %0d items over 11 ring settings, token count limits and round limit",
                 items_in);
        $display("checked %0d results: %0d tokens, %0d broadcasts, %0d gvt sets",
                 results_checked, tokens_seen, broadcasts_seen, gvt_sets_seen);
        $display("  with %0d periods elapsed and %0d fossil collects", periods_seen,
                 fossils_seen);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #10000000;
        $display("status: fail");
        $finish;
    end

endmodule
